@@ hw/rtl/mbrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrc_pkg: shared definitions of the Modbus RTU request checker
// Verdict codes, function codes, the result layout and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'h01;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'hA001;

  localparam logic [7:0] CODE_READ  = 8'h03;
  localparam logic [7:0] CODE_WRITE = 8'h06;

  localparam logic [2:0] FRAME_LAST_POS = 3'd7;
  localparam logic [2:0] CRC_LAST_POS   = 3'd5;

  typedef enum logic [2:0] {
    VERDICT_READ     = 3'd0,
    VERDICT_WRITE    = 3'd1,
    VERDICT_BAD_FUNC = 3'd2,
    VERDICT_BAD_CRC  = 3'd3,
    VERDICT_BAD_ADDR = 3'd4
  } verdict_t;

  // The first member sits in the highest bits, so verdict ends up at bit 0.
  typedef struct packed {
    logic [15:0] computed_crc;
    logic [15:0] register_count;
    logic [15:0] start_register;
    logic [7:0]  function_code;
    verdict_t    verdict;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  // Reflected CRC-16 update by one byte, eight shift steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

@@ hw/rtl/modbus_rtu_request_checker_core.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_request_checker_core: Modbus RTU request frame checker
// Collects fixed 8-byte request frames and reports one verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Request bytes enter on the s_axis channel, one byte per request, with
//   s_axis_tuser marking byte zero of a new frame. A flag in the middle of a
//   frame drops the partial frame. Without a flag, the byte after the eighth
//   starts a new frame.
//   After the eighth byte a result leaves on the m_axis channel: the verdict,
//   the function code, start register, register count and the CRC-16 of the
//   first six bytes. The result is registered and valid in the cycle after the eighth
//   byte is accepted, unless an earlier result is still stalled at the output.
//   One byte is taken every cycle while s_axis_tready is high. A byte-wide
//   CRC update between the input port and the CRC register sets the cycle time.
//   When the receiver stalls, a second result register catches one more
//   result; s_axis_tready drops only while that register is occupied.
//   Reset clears the frame position and both result registers, loads the CRC
//   with 0xFFFF and sets the slave address to 1. Write cfg_wdata with cfg_we
//   to change it while no frame is in progress.
// ----------------------------------------------------------------------------
module modbus_rtu_request_checker_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata,      // slave_address
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  input  logic                        s_axis_tuser,   // [0] frame_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [mbrc_pkg::TDATA_W-1:0] m_axis_tdata   // [2:0] verdict,
                                                      // [10:3] function_code,
                                                      // [26:11] start_register,
                                                      // [42:27] register_count,
                                                      // [58:43] computed_crc
);

  logic [7:0]  slave_address;
  logic [2:0]  byte_position;
  logic [15:0] running_crc;
  logic [7:0]  address_byte;
  logic [7:0]  function_byte;
  logic [15:0] start_register;
  logic [15:0] register_count;
  logic [7:0]  crc_low_received;

  logic                out_valid;
  mbrc_pkg::result_t   out_data;
  logic                skid_valid;
  mbrc_pkg::result_t   skid_data;

  logic                accept;
  logic [2:0]          pos;
  logic [15:0]         crc_base;
  logic [15:0]         crc_next;
  logic                frame_done;
  mbrc_pkg::verdict_t  verdict;
  mbrc_pkg::result_t   result;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !skid_valid;
  assign pos           = s_axis_tuser ? 3'd0 : byte_position;
  assign crc_base      = (pos == 3'd0) ? mbrc_pkg::CRC_INIT : running_crc;
  assign crc_next      = mbrc_pkg::crc16_byte(crc_base, s_axis_tdata);
  assign frame_done    = accept && (pos == mbrc_pkg::FRAME_LAST_POS);

  always_comb begin
    if (address_byte != slave_address) begin
      verdict = mbrc_pkg::VERDICT_BAD_ADDR;
    end else if (crc_low_received != running_crc[7:0] ||
                 s_axis_tdata != running_crc[15:8]) begin
      verdict = mbrc_pkg::VERDICT_BAD_CRC;
    end else if (function_byte == mbrc_pkg::CODE_READ) begin
      verdict = mbrc_pkg::VERDICT_READ;
    end else if (function_byte == mbrc_pkg::CODE_WRITE) begin
      verdict = mbrc_pkg::VERDICT_WRITE;
    end else begin
      verdict = mbrc_pkg::VERDICT_BAD_FUNC;
    end
    result.verdict        = verdict;
    result.function_code  = function_byte;
    result.start_register = start_register;
    result.register_count = register_count;
    result.computed_crc   = running_crc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= mbrc_pkg::SLAVE_ADDRESS_RESET;
    end else if (cfg_we) begin
      slave_address <= cfg_wdata;
    end
  end

  // Frame collection.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 3'd0;
      running_crc      <= mbrc_pkg::CRC_INIT;
      address_byte     <= 8'h00;
      function_byte    <= 8'h00;
      start_register   <= 16'h0000;
      register_count   <= 16'h0000;
      crc_low_received <= 8'h00;
    end else if (accept) begin
      if (pos <= mbrc_pkg::CRC_LAST_POS) begin
        running_crc <= crc_next;
      end
      case (pos)
        3'd0: address_byte          <= s_axis_tdata;
        3'd1: function_byte         <= s_axis_tdata;
        3'd2: start_register[15:8]  <= s_axis_tdata;
        3'd3: start_register[7:0]   <= s_axis_tdata;
        3'd4: register_count[15:8]  <= s_axis_tdata;
        3'd5: register_count[7:0]   <= s_axis_tdata;
        3'd6: crc_low_received      <= s_axis_tdata;
        default: ;
      endcase
      if (pos == mbrc_pkg::FRAME_LAST_POS) begin
        byte_position <= 3'd0;
        running_crc   <= mbrc_pkg::CRC_INIT;
      end else begin
        byte_position <= pos + 3'd1;
      end
    end
  end

  // Result register with a skid register behind it. A new result arrives
  // only while the skid register is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
        if (frame_done) begin
          out_valid <= 1'b1;
        end
      end else if (frame_done) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && m_axis_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (frame_done) begin
        out_data <= result;
      end
    end else if (frame_done) begin
      if (out_valid) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(mbrc_pkg::TDATA_W - mbrc_pkg::RESULT_W){1'b0}}, out_data};

endmodule

@@ hw/rtl/mbrc_checker.sv @@
// ----------------------------------------------------------------------------
// mbrc_checker: port assertions for the Modbus RTU request checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module mbrc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [mbrc_pkg::TDATA_W-1:0] m_axis_tdata
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= mbrc_pkg::VERDICT_BAD_ADDR)
    else $error("verdict code out of range");

  // An accepted read or write must carry the matching function code.
  a_code_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[2:0] == mbrc_pkg::VERDICT_READ ||
                      m_axis_tdata[2:0] == mbrc_pkg::VERDICT_WRITE) |->
      (m_axis_tdata[10:3] == ((m_axis_tdata[2:0] == mbrc_pkg::VERDICT_READ) ?
                              mbrc_pkg::CODE_READ : mbrc_pkg::CODE_WRITE)))
    else $error("verdict does not match function code");

endmodule

bind modbus_rtu_request_checker_core mbrc_checker u_mbrc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
